// File: design/mwss_pkg.sv
// constants, types and the quarter-wave sine table of the waveform synthesiser
// no dependencies
package mwss_pkg;

  localparam int unsigned OSCILLATORS   = 7;
  localparam int unsigned MAX_HARMONICS = 64;
  localparam int unsigned SINE_ROM_BITS = 10;
  localparam int unsigned PHASE_BITS    = 32;

  localparam int unsigned REG_W    = 57;
  localparam int unsigned CTRL_W   = 10;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned DIV_W    = 32;
  localparam int unsigned MUL_A_W  = 33;
  localparam int unsigned MUL_B_W  = 32;
  localparam int unsigned MUL_P_W  = MUL_A_W + MUL_B_W;

  localparam int unsigned ROM_SIZE = 1 << SINE_ROM_BITS;
  localparam int unsigned QUARTER  = ROM_SIZE / 4;
  localparam int unsigned QAW      = SINE_ROM_BITS - 1;

  localparam int unsigned CNT_W  = $clog2(MAX_HARMONICS + 1);
  localparam int unsigned N_W    = $clog2(MAX_HARMONICS + 3);
  localparam int unsigned TERM_W = 29;
  localparam int unsigned SUM_W  = TERM_W + CNT_W;
  localparam int unsigned WAVE_W = 18;
  localparam int unsigned ACC_W  = 30;
  localparam int unsigned MAG_W  = 22;
  localparam int unsigned BIG_W  = 96;

  localparam logic [14:0] FULL_U    = 15'd32767;
  localparam logic [31:0] FULL_MIX  = 32'd3276700;
  localparam logic [31:0] HALF_MIX  = 32'd1638350;
  // ceil(2^32/100): exact quotient by 100 for dividends below 2^30
  localparam logic [31:0] PCT_RECIP = 32'd42949673;
  localparam logic [31:0] PCT_HALF  = 32'd50;
  localparam logic [30:0] K_SQUARE  = 31'd1367130551;
  localparam logic [30:0] K_TRI     = 31'd870342340;
  localparam logic [30:0] K_SAW     = 31'd683565276;

  // register indexes
  localparam logic [IDX_W-1:0] REG_SQUARE = 3'd4;
  localparam logic [IDX_W-1:0] REG_TRI    = 3'd5;
  localparam logic [IDX_W-1:0] REG_SAW    = 3'd6;
  localparam logic [IDX_W-1:0] REG_COMB   = 3'd3;
  localparam logic [IDX_W-1:0] REG_CTRL   = 3'd7;

  // operating modes
  localparam logic [1:0] MODE_IDEAL = 2'd0;
  localparam logic [1:0] MODE_FIXED = 2'd2;

  localparam logic [REG_W-1:0] OSC_RESET [OSCILLATORS] = '{
    57'd21940368073, 57'd43880736456, 57'd65821104328, 57'd21940368072,
    57'd21940368072, 57'd21940368072, 57'd21940368072
  };
  localparam logic [CTRL_W-1:0] CTRL_RESET = 10'd80;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef logic signed [15:0] qtab_t [QUARTER+1];

  // round(32767*sin(2*pi*r/ROM_SIZE)) by a Taylor series in Q30
  function automatic logic signed [15:0] quarter_sine(input int unsigned r);
    logic [63:0] x, x2, t, s, v;
    x  = (64'(r) * 64'd6746518852) >> SINE_ROM_BITS;
    x2 = (x * x) >> 30;
    t  = (64'd1 << 30) - x2 / 110;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 72;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) v = 64'd32767;
    return 16'(v);
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t q;
    for (int unsigned k = 0; k <= QUARTER; k++) q[k] = quarter_sine(k);
    return q;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  // full-wave lookup on the top bits of a phase, by quadrant symmetry
  function automatic logic signed [15:0] sine_of(input logic [PHASE_BITS-1:0] ph);
    logic [SINE_ROM_BITS-1:0] a;
    logic [QAW-1:0]           r;
    logic signed [15:0]       v;
    a = ph[PHASE_BITS-1 -: SINE_ROM_BITS];
    r = {1'b0, a[SINE_ROM_BITS-3:0]};
    if (a[SINE_ROM_BITS-2]) r = QAW'(QUARTER) - r;
    v = QTAB[r];
    return a[SINE_ROM_BITS-1] ? -v : v;
  endfunction

endpackage

// File: design/mwss_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on mwss_pkg
module mwss_div import mwss_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CW = $clog2(DIV_W + 1);

  logic [CW-1:0]    count_q;
  logic             run_q, done_q;
  logic [DIV_W:0]   rem_q;
  logic [DIV_W-1:0] quo_q, dsr_q;
  logic [DIV_W:0]   rem_sh;

  assign rem_sh = {rem_q[DIV_W-1:0], quo_q[DIV_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      run_q   <= 1'b0;
      done_q  <= 1'b0;
      rem_q   <= '0;
      quo_q   <= '0;
      dsr_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !run_q) begin
        run_q   <= 1'b1;
        count_q <= CW'(DIV_W);
        rem_q   <= '0;
        quo_q   <= req_i.dividend;
        dsr_q   <= req_i.divisor;
      end else if (run_q) begin
        if (rem_sh >= {1'b0, dsr_q}) begin
          rem_q <= rem_sh - {1'b0, dsr_q};
          quo_q <= {quo_q[DIV_W-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[DIV_W-2:0], 1'b0};
        end
        count_q <= count_q - CW'(1);
        if (count_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// File: design/multi_waveform_sample_synth_unit.sv
// top level of the additive waveform synthesiser: sequencer, shared multiplier
// depends on mwss_pkg and mwss_div
//
// One item is a sample index; the block returns one pcm sample for it. An
// item is taken when start is high and busy is low, and busy stays high
// until the result strobe done_o, which lasts one cycle and cannot be held
// off: capture pcm_word_o, pcm_byte_o and clipped_o on that cycle. Work on
// an item runs through one shared multiplier and one shared 32-step divider.
// A disabled oscillator is skipped in S_OSC. An enabled sine, comb or ideal
// square wave is formed directly from the phase; an ideal triangle or saw
// is scaled through the multiplier. A band-limited wave sums harmonic terms:
// the first needs no division and each further one waits on the divider,
// as does the harmonic count in the nyquist mode when the increment is not
// zero; the final scaling and rounding follow. Configuration writes are
// always taken and must only be made while busy is low.
module multi_waveform_sample_synth_unit import mwss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [31:0]       sample_index_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [IDX_W-1:0]  cfg_index_i,
  input  logic [REG_W-1:0]  cfg_data_i,
  output logic              done_o,
  output logic signed [15:0] pcm_word_o,
  output logic [7:0]        pcm_byte_o,
  output logic              clipped_o
);

  localparam int unsigned PB = PHASE_BITS;

  typedef enum logic [4:0] {
    S_IDLE, S_OSC, S_PH_MUL, S_PH_ADD, S_KIND, S_ID_MUL, S_ID_RND,
    S_CNT_WAIT, S_BL_INIT, S_BL_TEST, S_BL_DEN, S_BL_DIVS, S_BL_DIVW,
    S_BL_ACC, S_K_LO, S_K_HI, S_K_SUM, S_K_RND, S_MAC_MUL, S_MAC_ADD,
    S_FIN, S_FIN_DIV, S_FIN_WAIT
  } state_e;

  state_e state_q;

  // configuration
  logic [REG_W-1:0]  osc_q [OSCILLATORS];
  logic [CTRL_W-1:0] ctrl_q;

  // working registers
  logic [IDX_W-1:0]         osc_sel_q;
  logic [31:0]              idx_q;
  logic [PB-1:0]            ph_q, hp_q, hstep_q;
  logic [PB:0]              vmag_q;
  logic                     vneg_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [N_W-1:0]           n_q;
  logic                     alt_q;
  logic signed [15:0]       s_q;
  logic signed [TERM_W-1:0] term_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [WAVE_W-1:0] w_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic [MUL_P_W-1:0]       prod_q;
  logic [BIG_W-1:0]         big_q;
  logic                     msign_q;
  logic [MAG_W-1:0]         mag_q;
  logic                     fneg_q, clip_q;
  logic                     done_q;
  logic signed [15:0]       word_q;
  logic [7:0]               byte_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  mwss_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // fields of the oscillator in hand
  logic [REG_W-1:0]  cur;
  logic              en;
  logic signed [7:0] amp;
  logic [PB-1:0]     inc;
  logic [15:0]       sph;
  logic [1:0]        mode;
  logic              eight;
  logic [6:0]        fixed_cnt;
  logic              last_osc;
  logic [30:0]       kconst;
  logic [SUM_W-1:0]  sum_mag;
  logic [63:0]       sum_mag64;
  logic [7:0]        amp_mag;
  logic [WAVE_W-1:0] w_mag;

  assign cur       = osc_q[osc_sel_q];
  assign en        = cur[0];
  assign amp       = cur[8:1];
  assign inc       = cur[9 +: PB];
  assign sph       = cur[56:41];
  assign mode      = ctrl_q[1:0];
  assign eight     = ctrl_q[2];
  assign fixed_cnt = ctrl_q[9:3];
  assign last_osc  = (osc_sel_q == IDX_W'(OSCILLATORS - 1));
  assign sum_mag   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign sum_mag64 = 64'(sum_mag);
  assign amp_mag   = amp[7] ? 8'(-amp) : 8'(amp);
  assign w_mag     = w_q[WAVE_W-1] ? WAVE_W'(-w_q) : WAVE_W'(w_q);

  always_comb begin
    case (osc_sel_q)
      REG_SQUARE: kconst = K_SQUARE;
      REG_TRI:    kconst = K_TRI;
      default:    kconst = K_SAW;
    endcase
  end

  // ideal triangle and saw before scaling: full - 4|g - half| or full - 2g
  logic [PB-1:0]         g_tri, g_saw;
  logic signed [PB+3:0]  d_tri, v_id;

  assign g_tri = ph_q + PB'(1 << (PB - 2));
  assign g_saw = ph_q + PB'(1 << (PB - 1));
  assign d_tri = $signed({4'b0, g_tri}) - $signed((PB+4)'(1) << (PB - 1));

  always_comb begin
    if (osc_sel_q == REG_TRI) begin
      v_id = ((PB+4)'(1) << PB) - ((d_tri < 0 ? -d_tri : d_tri) <<< 2);
    end else begin
      v_id = ((PB+4)'(1) << PB) - ($signed({4'b0, g_saw}) <<< 1);
    end
  end

  // final rounding: numerator, then a quotient by 100 through the reciprocal
  logic [31:0]      mag127;
  logic [31:0]      fin_num;
  logic [22:0]      fin_y;
  logic [7:0]       fin_q0;
  logic [15:0]      fin_r;
  logic [7:0]       fin_q;

  assign mag127  = (32'(mag_q) << 7) - 32'(mag_q);
  assign fin_num = eight ? mag127 + HALF_MIX : 32'(mag_q) + PCT_HALF;
  assign fin_y   = prod_q[54:32];
  // eight-bit mode: further quotient by 32767 = 2^15 - 1, one correction step
  assign fin_q0  = fin_y[22:15];
  assign fin_r   = {1'b0, fin_y[14:0]} + {8'b0, fin_q0};
  assign fin_q   = fin_q0 + ((fin_r >= {1'b0, FULL_U}) ? 8'd1 : 8'd0);

  // shared multiplier operand selection
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_PH_MUL: begin
        mul_a = MUL_A_W'(idx_q);
        mul_b = MUL_B_W'(inc);
      end
      S_ID_MUL: begin
        mul_a = MUL_A_W'(vmag_q);
        mul_b = MUL_B_W'(FULL_U);
      end
      S_BL_DEN: begin
        mul_a = MUL_A_W'(n_q);
        mul_b = (osc_sel_q == REG_TRI) ? MUL_B_W'(n_q) : MUL_B_W'(1);
      end
      S_K_LO: begin
        mul_a = MUL_A_W'(sum_mag64[31:0]);
        mul_b = MUL_B_W'(kconst);
      end
      S_K_HI: begin
        mul_a = MUL_A_W'(sum_mag64[63:32]);
        mul_b = MUL_B_W'(kconst);
      end
      S_MAC_MUL: begin
        mul_a = MUL_A_W'(amp_mag);
        mul_b = MUL_B_W'(w_mag);
      end
      S_FIN_DIV: begin
        mul_a = MUL_A_W'(fin_num);
        mul_b = MUL_B_W'(PCT_RECIP);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divider requests: harmonic count and term rounding
  logic [2*N_W-1:0] den;
  logic [15:0]      s_mag;

  assign den    = prod_q[2*N_W-1:0];
  assign s_mag  = s_q[15] ? 16'(-s_q) : 16'(s_q);

  always_comb begin
    div_req = '0;
    case (state_q)
      S_KIND: begin
        div_req.dividend = 32'(1) << (PB - 1);
        div_req.divisor  = 32'(inc);
        div_req.start    = (osc_sel_q >= REG_SQUARE) && (mode != MODE_IDEAL) &&
                           (mode != MODE_FIXED) && (inc != '0);
      end
      S_BL_DIVS: begin
        div_req.dividend = (32'(s_mag) << 13) + 32'(den);
        div_req.divisor  = 32'(den) << 1;
        div_req.start    = (den != (2*N_W)'(1));
      end
      default: div_req = '0;
    endcase
  end

  logic [31:0] cnt_raw;
  assign cnt_raw = (mode == MODE_FIXED) ? 32'(fixed_cnt) :
                   (inc == '0) ? 32'(MAX_HARMONICS) : div_rsp.quotient;

  logic [BIG_W-1:0] big_rnd;
  assign big_rnd = big_q >> 42;

  logic signed [15:0] rom_ph, rom_hp;
  assign rom_ph = sine_of(ph_q);
  assign rom_hp = sine_of(hp_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      osc_q     <= OSC_RESET;
      ctrl_q    <= CTRL_RESET;
      osc_sel_q <= '0;
      idx_q     <= '0;
      ph_q      <= '0;
      hp_q      <= '0;
      hstep_q   <= '0;
      vmag_q    <= '0;
      vneg_q    <= 1'b0;
      cnt_q     <= '0;
      n_q       <= '0;
      alt_q     <= 1'b0;
      s_q       <= '0;
      term_q    <= '0;
      sum_q     <= '0;
      w_q       <= '0;
      acc_q     <= '0;
      prod_q    <= '0;
      big_q     <= '0;
      msign_q   <= 1'b0;
      mag_q     <= '0;
      fneg_q    <= 1'b0;
      clip_q    <= 1'b0;
      done_q    <= 1'b0;
      word_q    <= '0;
      byte_q    <= 8'd128;
    end else begin
      done_q <= 1'b0;
      prod_q <= mul_a * mul_b;

      if (cfg_valid_i) begin
        if (cfg_index_i == REG_CTRL) ctrl_q <= cfg_data_i[CTRL_W-1:0];
        else osc_q[cfg_index_i] <= cfg_data_i;
      end

      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            idx_q     <= sample_index_i;
            osc_sel_q <= '0;
            acc_q     <= '0;
            state_q   <= S_OSC;
          end
        end
        // skip disabled oscillators
        S_OSC: begin
          if (en) state_q <= S_PH_MUL;
          else if (last_osc) state_q <= S_FIN;
          else osc_sel_q <= osc_sel_q + IDX_W'(1);
        end
        S_PH_MUL: state_q <= S_PH_ADD;
        S_PH_ADD: begin
          ph_q    <= (PB'(sph) << (PB - 16)) + prod_q[PB-1:0];
          state_q <= S_KIND;
        end
        S_KIND: begin
          if (osc_sel_q < REG_COMB) begin
            w_q     <= WAVE_W'(rom_ph);
            state_q <= S_MAC_MUL;
          end else if (osc_sel_q == REG_COMB) begin
            w_q     <= (ph_q < inc) ? WAVE_W'(FULL_U) : '0;
            state_q <= S_MAC_MUL;
          end else if (mode == MODE_IDEAL) begin
            if (osc_sel_q == REG_SQUARE) begin
              w_q     <= ph_q[PB-1] ? -WAVE_W'(FULL_U) : WAVE_W'(FULL_U);
              state_q <= S_MAC_MUL;
            end else begin
              vmag_q  <= (PB+1)'(v_id < 0 ? -v_id : v_id);
              vneg_q  <= v_id < 0;
              state_q <= S_ID_MUL;
            end
          end else if (div_req.start) begin
            state_q <= S_CNT_WAIT;
          end else begin
            cnt_q   <= (cnt_raw > 32'(MAX_HARMONICS)) ? CNT_W'(MAX_HARMONICS)
                                                      : CNT_W'(cnt_raw);
            state_q <= S_BL_INIT;
          end
        end
        S_ID_MUL: state_q <= S_ID_RND;
        S_ID_RND: begin
          w_q <= vneg_q ? -WAVE_W'((prod_q + (MUL_P_W'(1) << (PB - 1))) >> PB)
                        :  WAVE_W'((prod_q + (MUL_P_W'(1) << (PB - 1))) >> PB);
          state_q <= S_MAC_MUL;
        end
        S_CNT_WAIT: begin
          if (div_rsp.done) begin
            cnt_q   <= (cnt_raw > 32'(MAX_HARMONICS)) ? CNT_W'(MAX_HARMONICS)
                                                      : CNT_W'(cnt_raw);
            state_q <= S_BL_INIT;
          end
        end
        S_BL_INIT: begin
          hp_q    <= ph_q;
          hstep_q <= (osc_sel_q == REG_SAW) ? ph_q : (ph_q << 1);
          n_q     <= N_W'(1);
          alt_q   <= 1'b0;
          sum_q   <= '0;
          state_q <= S_BL_TEST;
        end
        S_BL_TEST: begin
          if (n_q > N_W'(cnt_q)) begin
            state_q <= S_K_LO;
          end else begin
            s_q     <= rom_hp;
            state_q <= S_BL_DEN;
          end
        end
        S_BL_DEN: state_q <= S_BL_DIVS;
        // first harmonic needs no division
        S_BL_DIVS: begin
          if (den == (2*N_W)'(1)) begin
            term_q  <= TERM_W'(s_q) <<< 12;
            state_q <= S_BL_ACC;
          end else begin
            state_q <= S_BL_DIVW;
          end
        end
        S_BL_DIVW: begin
          if (div_rsp.done) begin
            term_q  <= s_q[15] ? -TERM_W'(div_rsp.quotient) : TERM_W'(div_rsp.quotient);
            state_q <= S_BL_ACC;
          end
        end
        S_BL_ACC: begin
          if (osc_sel_q == REG_SQUARE || !alt_q) sum_q <= sum_q + SUM_W'(term_q);
          else sum_q <= sum_q - SUM_W'(term_q);
          alt_q   <= !alt_q;
          n_q     <= n_q + ((osc_sel_q == REG_SAW) ? N_W'(1) : N_W'(2));
          hp_q    <= hp_q + hstep_q;
          state_q <= S_BL_TEST;
        end
        S_K_LO: state_q <= S_K_HI;
        S_K_HI: begin
          big_q   <= BIG_W'(prod_q);
          state_q <= S_K_SUM;
        end
        S_K_SUM: begin
          big_q   <= big_q + (BIG_W'(prod_q) << 32) + (BIG_W'(1) << 41);
          state_q <= S_K_RND;
        end
        S_K_RND: begin
          w_q     <= sum_q[SUM_W-1] ? -WAVE_W'(big_rnd) : WAVE_W'(big_rnd);
          state_q <= S_MAC_MUL;
        end
        S_MAC_MUL: begin
          msign_q <= amp[7] ^ w_q[WAVE_W-1];
          state_q <= S_MAC_ADD;
        end
        S_MAC_ADD: begin
          acc_q <= msign_q ? acc_q - ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
          if (last_osc) begin
            state_q <= S_FIN;
          end else begin
            osc_sel_q <= osc_sel_q + IDX_W'(1);
            state_q   <= S_OSC;
          end
        end
        // clip to full scale
        S_FIN: begin
          fneg_q <= acc_q[ACC_W-1];
          if (acc_q > $signed(ACC_W'(FULL_MIX))) begin
            mag_q  <= MAG_W'(FULL_MIX);
            clip_q <= 1'b1;
          end else if (acc_q < -$signed(ACC_W'(FULL_MIX))) begin
            mag_q  <= MAG_W'(FULL_MIX);
            clip_q <= 1'b1;
          end else begin
            mag_q  <= acc_q[ACC_W-1] ? MAG_W'(-acc_q) : MAG_W'(acc_q);
            clip_q <= 1'b0;
          end
          state_q <= S_FIN_DIV;
        end
        S_FIN_DIV: state_q <= S_FIN_WAIT;
        S_FIN_WAIT: begin
          if (eight) begin
            word_q <= '0;
            byte_q <= fneg_q ? 8'd128 - fin_q : 8'd128 + fin_q;
          end else begin
            word_q <= fneg_q ? -16'(fin_y) : 16'(fin_y);
            byte_q <= 8'd128;
          end
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign pcm_word_o  = word_q;
  assign pcm_byte_o  = byte_q;
  assign clipped_o   = clip_q;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("item taken but block not busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobe while still working");
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_CNT_WAIT || state_q == S_BL_DIVW))
    else $error("quotient not awaited");
  a_unused_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !eight) |-> (pcm_byte_o == 8'd128)) else $error("byte field not idle");
`endif

endmodule
